FILE: rtl/pdta_pkg.sv
// Shared types, constants and helper functions for the packed decimal to ASCII converter.
// Has no dependencies. Every other file in rtl/ imports it.
`default_nettype none
package pdta_pkg;

  localparam int DIGITS_PER_GROUP = 9;

  // Register indexes on the configuration port
  localparam logic [1:0] CFG_PRECISION = 2'd0;
  localparam logic [1:0] CFG_SCALE     = 2'd1;

  localparam logic [6:0] PREC_RST  = 7'd10;
  localparam logic [4:0] SCALE_RST = 5'd0;
  localparam logic [6:0] MAX_PREC  = 7'd65;

  localparam logic [3:0] FULL_GROUP_DIGITS = 4'd9;
  localparam logic [2:0] FULL_GROUP_BYTES  = 3'd4;

  localparam logic [7:0] SIGN_MASK = 8'h80;
  localparam logic [7:0] BYTE_ONES = 8'hff;

  localparam logic [7:0] CHAR_MINUS = 8'h2d;
  localparam logic [7:0] CHAR_DOT   = 8'h2e;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  // 1/10 reciprocal, exact for any 32-bit dividend with a shift of 35
  localparam logic [31:0] RECIP10       = 32'hcccc_cccd;
  localparam int          RECIP10_SHIFT = 35;

  typedef logic [DIGITS_PER_GROUP-1:0][3:0] digits_t;

  // Byte layout of the value, derived from precision and scale
  typedef struct packed {
    logic [2:0] lead;       // bytes in the partial leading integer group
    logic [5:0] int_bytes;  // bytes of the whole integer part
    logic [5:0] mid_end;    // end of the full fraction groups
    logic [2:0] tail;       // bytes in the partial trailing fraction group
    logic [5:0] total;      // bytes of the whole value
    logic [3:0] igx;        // digits in the leading integer group
    logic [3:0] fgx;        // digits in the trailing fraction group
  } geom_t;

  // One group's worth of work travelling down the digit chain
  typedef struct packed {
    logic [29:0] value;
    digits_t     digits;
    logic [3:0]  gdig;       // digits to print, zero if no group closed
    logic        ovf;
    logic        pre_minus;
    logic        pre_dot;
    logic        post_dot;
    logic        last;
  } rec_t;

  function automatic logic [2:0] dig_bytes(input logic [3:0] d);
    logic [2:0] b;
    case (d)
      4'd0:       b = 3'd0;
      4'd1, 4'd2: b = 3'd1;
      4'd3, 4'd4: b = 3'd2;
      4'd5, 4'd6: b = 3'd3;
      default:    b = 3'd4;
    endcase
    return b;
  endfunction

  // Largest value a group of d digits may hold
  function automatic logic [29:0] group_cap(input logic [3:0] d);
    logic [29:0] c;
    case (d)
      4'd0:    c = 30'd0;
      4'd1:    c = 30'd9;
      4'd2:    c = 30'd99;
      4'd3:    c = 30'd999;
      4'd4:    c = 30'd9999;
      4'd5:    c = 30'd99999;
      4'd6:    c = 30'd999999;
      4'd7:    c = 30'd9999999;
      4'd8:    c = 30'd99999999;
      default: c = 30'd999999999;
    endcase
    return c;
  endfunction

  // Split a digit count (at most 65) into full groups and leftover digits.
  // x/9 is taken as (x*57)>>9, exact over that range.
  function automatic geom_t calc_geom(input logic [6:0] prec, input logic [4:0] scl);
    logic [6:0]  p;
    logic [6:0]  s;
    logic [6:0]  intg;
    logic [12:0] mi;
    logic [12:0] mf;
    logic [3:0]  ig0;
    logic [3:0]  fg0;
    geom_t       g;
    if (prec == 7'd0) begin
      p = 7'd1;
    end else if (prec > MAX_PREC) begin
      p = MAX_PREC;
    end else begin
      p = prec;
    end
    s    = ({2'b00, scl} > p) ? p : {2'b00, scl};
    intg = p - s;
    mi   = {6'd0, intg} * 13'd57;
    mf   = {6'd0, s} * 13'd57;
    ig0  = mi[12:9];
    fg0  = mf[12:9];
    g.igx       = 4'(intg - ({3'b000, ig0} * 7'd9));
    g.fgx       = 4'(s - ({3'b000, fg0} * 7'd9));
    g.lead      = dig_bytes(g.igx);
    g.tail      = dig_bytes(g.fgx);
    g.int_bytes = {3'b000, g.lead} + {ig0, 2'b00};
    g.mid_end   = g.int_bytes + {fg0, 2'b00};
    g.total     = g.mid_end + {3'b000, g.tail};
    return g;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/pdta_front.sv
// Byte gatherer: configuration registers, value layout, sign handling and group assembly.
// Depends on pdta_pkg. Sends the chain a record on each closed group, leading sign or dot.
`default_nettype none
module pdta_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [1:0]      cfg_index_i,
  input  logic [6:0]      cfg_data_i,
  input  logic            fire_i,
  input  logic [7:0]      data_byte_i,
  output logic            rec_valid_o,
  output pdta_pkg::rec_t  rec_o
);
  import pdta_pkg::*;

  localparam geom_t GeomRst = calc_geom(PREC_RST, SCALE_RST);

  logic [6:0]  prec_q, prec_d;
  logic [4:0]  scale_q, scale_d;
  geom_t       geom_q, geom_d;
  logic [31:0] acc_q, acc_d;
  logic [5:0]  idx_q, idx_d;
  logic [2:0]  gbc_q, gbc_d;
  logic        neg_q, neg_d;

  logic [5:0]  p_eff;
  logic [5:0]  p_next;
  logic        first;
  logic        neg_now;
  logic [2:0]  gsize;
  logic [3:0]  gdig;
  logic [7:0]  bx;
  logic [31:0] acc_new;
  logic [2:0]  gbc_new;
  logic        done;
  logic        over;
  logic        is_last;
  logic [29:0] cap;

  always_comb begin
    p_eff   = (idx_q >= geom_q.total) ? 6'd0 : idx_q;
    p_next  = p_eff + 6'd1;
    first   = (p_eff == 6'd0);
    neg_now = first ? ~data_byte_i[7] : neg_q;

    if (p_eff < {3'b000, geom_q.lead}) begin
      gsize = geom_q.lead;
      gdig  = geom_q.igx;
    end else if (p_eff < geom_q.mid_end) begin
      gsize = FULL_GROUP_BYTES;
      gdig  = FULL_GROUP_DIGITS;
    end else begin
      gsize = geom_q.tail;
      gdig  = geom_q.fgx;
    end

    bx      = data_byte_i ^ (first ? SIGN_MASK : 8'h00) ^ (neg_now ? BYTE_ONES : 8'h00);
    acc_new = {(first ? 24'd0 : acc_q[23:0]), bx};
    gbc_new = (first ? 3'd0 : gbc_q) + 3'd1;
    done    = (gbc_new >= gsize);
    is_last = (p_next >= geom_q.total);
    cap     = group_cap(gdig);
    over    = (acc_new > {2'b00, cap});

    rec_o.value     = over ? cap : acc_new[29:0];
    rec_o.digits    = '0;
    rec_o.gdig      = done ? gdig : 4'd0;
    rec_o.ovf       = over;
    rec_o.pre_minus = first && neg_now;
    rec_o.pre_dot   = first && (geom_q.int_bytes == 6'd0);
    rec_o.post_dot  = done && (p_next == geom_q.int_bytes);
    rec_o.last      = is_last;
    rec_valid_o     = rec_o.pre_minus || rec_o.pre_dot || done;
  end

  always_comb begin
    prec_d  = prec_q;
    scale_d = scale_q;
    geom_d  = geom_q;
    acc_d   = acc_q;
    idx_d   = idx_q;
    gbc_d   = gbc_q;
    neg_d   = neg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_PRECISION: begin
          prec_d = cfg_data_i;
          geom_d = calc_geom(cfg_data_i, scale_q);
          acc_d  = '0;
          idx_d  = '0;
          gbc_d  = '0;
          neg_d  = 1'b0;
        end
        CFG_SCALE: begin
          scale_d = cfg_data_i[4:0];
          geom_d  = calc_geom(prec_q, cfg_data_i[4:0]);
          acc_d   = '0;
          idx_d   = '0;
          gbc_d   = '0;
          neg_d   = 1'b0;
        end
        default: begin
        end
      endcase
    end else if (fire_i) begin
      if (is_last) begin
        acc_d = '0;
        idx_d = '0;
        gbc_d = '0;
        neg_d = 1'b0;
      end else begin
        acc_d = done ? 32'd0 : acc_new;
        gbc_d = done ? 3'd0 : gbc_new;
        idx_d = p_next;
        neg_d = neg_now;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prec_q  <= PREC_RST;
      scale_q <= SCALE_RST;
      geom_q  <= GeomRst;
      acc_q   <= '0;
      idx_q   <= '0;
      gbc_q   <= '0;
      neg_q   <= 1'b0;
    end else begin
      prec_q  <= prec_d;
      scale_q <= scale_d;
      geom_q  <= geom_d;
      acc_q   <= acc_d;
      idx_q   <= idx_d;
      gbc_q   <= gbc_d;
      neg_q   <= neg_d;
    end
  end

`ifndef SYNTHESIS
  a_cfg_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i && (cfg_index_i == CFG_PRECISION || cfg_index_i == CFG_SCALE)
    |=> idx_q == 6'd0 && gbc_q == 3'd0)
    else $error("configuration write did not restart the value");
`endif

endmodule
`default_nettype wire

FILE: rtl/pdta_cell.sv
// One cell of the digit chain: holds a record, peels off its lowest decimal digit.
// Depends on pdta_pkg. Cells are chained by the top level and move in lockstep.
`default_nettype none
module pdta_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            adv_i,
  input  logic            valid_i,
  input  pdta_pkg::rec_t  rec_i,
  output logic            valid_o,
  output pdta_pkg::rec_t  rec_o
);
  import pdta_pkg::*;

  logic        valid_q;
  rec_t        rec_q;
  logic [61:0] prod;
  logic [29:0] quot;
  logic [6:0]  q10_lo;
  logic [3:0]  digit;

  always_comb begin
    prod   = {32'd0, rec_q.value} * {30'd0, RECIP10};
    quot   = {3'b000, prod[61:RECIP10_SHIFT]};
    // only the low nibble of quot*10 matters for the remainder
    q10_lo = {quot[3:0], 3'b000} + {2'b00, quot[3:0], 1'b0};
    digit  = rec_q.value[3:0] - q10_lo[3:0];

    rec_o        = rec_q;
    rec_o.value  = quot;
    rec_o.digits = {digit, rec_q.digits[DIGITS_PER_GROUP-1:1]};
    valid_o      = valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      rec_q <= rec_i;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/pdta_emit.sv
// Character emitter: turns one finished record into '-', '.', and digit items.
// Depends on pdta_pkg. Owns the output register of the result channel.
`default_nettype none
module pdta_emit (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            tail_valid_i,
  input  pdta_pkg::rec_t  tail_rec_i,
  output logic            take_o,
  input  logic            out_ready_i,
  output logic            out_valid_o,
  output logic [7:0]      text_char_o,
  output logic            is_last_o,
  output logic            group_overflow_o
);
  import pdta_pkg::*;

  logic       minus_q, minus_d;
  logic       predot_q, predot_d;
  logic [3:0] dl_q, dl_d;
  logic       postdot_q, postdot_d;
  digits_t    digits_q;
  logic       ovf_q;
  logic       last_q;
  logic       out_valid_q, out_valid_d;
  logic [7:0] char_q;
  logic       is_last_q;
  logic       govf_q;

  logic       busy;
  logic [4:0] remaining;
  logic       last_char;
  logic [3:0] dig_idx;
  logic       is_digit;
  logic [7:0] cur_char;
  logic       load;
  logic       take;

  always_comb begin
    busy      = minus_q || predot_q || (dl_q != 4'd0) || postdot_q;
    remaining = {4'd0, minus_q} + {4'd0, predot_q} + {1'b0, dl_q} + {4'd0, postdot_q};
    last_char = (remaining == 5'd1);
    dig_idx   = dl_q - 4'd1;
    is_digit  = 1'b0;
    if (minus_q) begin
      cur_char = CHAR_MINUS;
    end else if (predot_q) begin
      cur_char = CHAR_DOT;
    end else if (dl_q != 4'd0) begin
      cur_char = CHAR_ZERO + {4'd0, digits_q[dig_idx]};
      is_digit = 1'b1;
    end else begin
      cur_char = CHAR_DOT;
    end
    load = busy && (!out_valid_q || out_ready_i);
    // a new record may come in as the previous one hands over its final item
    take = tail_valid_i && (!busy || (load && last_char));
  end

  always_comb begin
    minus_d     = minus_q;
    predot_d    = predot_q;
    dl_d        = dl_q;
    postdot_d   = postdot_q;
    out_valid_d = out_valid_q;
    if (take) begin
      minus_d   = tail_rec_i.pre_minus;
      predot_d  = tail_rec_i.pre_dot;
      dl_d      = tail_rec_i.gdig;
      postdot_d = tail_rec_i.post_dot;
    end else if (load) begin
      if (minus_q) begin
        minus_d = 1'b0;
      end else if (predot_q) begin
        predot_d = 1'b0;
      end else if (dl_q != 4'd0) begin
        dl_d = dl_q - 4'd1;
      end else begin
        postdot_d = 1'b0;
      end
    end
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      minus_q     <= 1'b0;
      predot_q    <= 1'b0;
      dl_q        <= '0;
      postdot_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      minus_q     <= minus_d;
      predot_q    <= predot_d;
      dl_q        <= dl_d;
      postdot_q   <= postdot_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      digits_q <= tail_rec_i.digits;
      ovf_q    <= tail_rec_i.ovf;
      last_q   <= tail_rec_i.last;
    end
    if (load) begin
      char_q    <= cur_char;
      is_last_q <= last_q && last_char;
      govf_q    <= ovf_q && is_digit;
    end
  end

  assign take_o           = take;
  assign out_valid_o      = out_valid_q;
  assign text_char_o      = char_q;
  assign is_last_o        = is_last_q;
  assign group_overflow_o = govf_q;

endmodule
`default_nettype wire

FILE: rtl/packed_decimal_to_ascii_core.sv
// Top level of the packed decimal to ASCII converter: front end, digit chain, emitter.
// Depends on pdta_pkg, pdta_front, pdta_cell and pdta_emit.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o, data_byte_i) takes the bytes of one packed
//   decimal, most significant first. Result channel (out_valid_o/out_ready_i) gives one
//   ASCII item per transfer: '-', digits and '.', with is_last_o on the final item of a
//   value and group_overflow_o on the digits of a group that saturated.
//   Configuration channel (cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i) writes
//   precision (index 0) or scale (index 1); it is always ready and restarts the value.
// Path: the byte that closes a group reaches the output through the chain. The first of
//   the nine chain cells loads on that byte's accepting edge, the other eight follow in
//   turn, then the emitter's record register and then its output register.
// Throughput: bytes that only extend a group go in at one per cycle while the chain moves.
//   The emitter puts out one item per cycle while the receiver is ready, so the sustained
//   byte rate is set by the digits each group prints and the single item output register.
// Reset: precision 10, scale 0, no value in progress, chain and output empty.
// Stall: while the receiver holds off, the emitter keeps its item; once a finished
//   record waits at the end of the chain, the chain and the input stop as well.
`default_nettype none
module packed_decimal_to_ascii_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [6:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] text_char_o,
  output logic       is_last_o,
  output logic       group_overflow_o
);
  import pdta_pkg::*;

  localparam int NumCells = DIGITS_PER_GROUP;

  logic adv;
  logic in_fire;
  logic take;
  logic front_valid;
  rec_t front_rec;

  // chain taps: entry k feeds cell k, entry NumCells is the chain output
  logic chain_valid [NumCells+1];
  rec_t chain_rec   [NumCells+1];

  assign cfg_ready_o = 1'b1;
  // everything moves together unless a finished record is stuck at the end
  assign adv         = !chain_valid[NumCells] || take;
  assign in_ready_o  = adv;
  assign in_fire     = in_valid_i && adv;

  pdta_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .fire_i      (in_fire),
    .data_byte_i (data_byte_i),
    .rec_valid_o (front_valid),
    .rec_o       (front_rec)
  );

  assign chain_valid[0] = in_fire && front_valid;
  assign chain_rec[0]   = front_rec;

  // one cell per decimal digit, least significant digit first
  for (genvar k = 0; k < NumCells; k++) begin : g_cell
    pdta_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .valid_i (chain_valid[k]),
      .rec_i   (chain_rec[k]),
      .valid_o (chain_valid[k+1]),
      .rec_o   (chain_rec[k+1])
    );
  end

  pdta_emit u_emit (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .tail_valid_i     (chain_valid[NumCells]),
    .tail_rec_i       (chain_rec[NumCells]),
    .take_o           (take),
    .out_ready_i      (out_ready_i),
    .out_valid_o      (out_valid_o),
    .text_char_o      (text_char_o),
    .is_last_o        (is_last_o),
    .group_overflow_o (group_overflow_o)
  );

`ifndef SYNTHESIS
  a_ovf_on_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && group_overflow_o
    |-> text_char_o >= CHAR_ZERO && text_char_o <= CHAR_NINE)
    else $error("overflow flag on a non-digit item");

  a_char_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && text_char_o != CHAR_MINUS && text_char_o != CHAR_DOT
    |-> text_char_o >= CHAR_ZERO && text_char_o <= CHAR_NINE)
    else $error("item outside the decimal character set");

  a_last_not_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_last_o |-> text_char_o != CHAR_MINUS)
    else $error("value ended on its sign");
`endif

endmodule
`default_nettype wire
